// File: rtl/mbps_pkg.sv
// Package for the masked byte pattern scanner.
// Holds the widths, action and register codes, sequencer states and the
// structs shared by the cell row, the alignment sequencer and the top level.
`default_nettype none

package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int IDX_W             = $clog2(MAX_PATTERN_BYTES);
    localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int BYTE_W            = 8;
    localparam int ADDR_W            = 32;
    localparam int ACTION_W          = 2;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 6;

    typedef logic [ACTION_W-1:0]  t_action;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_action ACT_WRITE_PATTERN = 2'd0;
    localparam t_action ACT_WRITE_MASK    = 2'd1;
    localparam t_action ACT_SCAN_BYTE     = 2'd2;

    localparam t_cfg_idx CFG_PATTERN_LENGTH  = 2'd0;
    localparam t_cfg_idx CFG_MASK_ENABLE     = 2'd1;
    localparam t_cfg_idx CFG_SEARCH_BACKWARD = 2'd2;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_LOAD,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic busy;
        logic load;
        logic shift;
    } t_align;

    typedef struct packed {
        logic              scan_shift;
        logic              align_load;
        logic              align_shift;
        logic              mask_en;
        logic              backward;
        logic [BYTE_W-1:0] byte_value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: rtl/mbps_cell.sv
// One cell of the scan row: a window byte, its pattern and mask bytes in both
// orders, and the masked compare of the byte entering this window position.
// Depends on mbps_pkg.
`default_nettype none

module mbps_cell
    import mbps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic              i_active,
    input  wire logic              i_pat_we,
    input  wire logic              i_msk_we,
    input  wire logic              i_apat_we,
    input  wire logic              i_amsk_we,
    input  wire logic [BYTE_W-1:0] i_win_in,
    input  wire logic [BYTE_W-1:0] i_rev_pat,
    input  wire logic [BYTE_W-1:0] i_rev_msk,
    input  wire logic [BYTE_W-1:0] i_next_apat,
    input  wire logic [BYTE_W-1:0] i_next_amsk,
    output logic      [BYTE_W-1:0] o_win,
    output logic      [BYTE_W-1:0] o_pat,
    output logic      [BYTE_W-1:0] o_msk,
    output logic      [BYTE_W-1:0] o_apat,
    output logic      [BYTE_W-1:0] o_amsk,
    output logic                   o_hit
);

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] r_pat;
    logic [BYTE_W-1:0] r_msk;
    logic [BYTE_W-1:0] r_apat;
    logic [BYTE_W-1:0] r_amsk;
    logic [BYTE_W-1:0] sel_pat;
    logic [BYTE_W-1:0] sel_msk;
    logic [BYTE_W-1:0] eff_msk;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan_shift) begin
            r_win <= i_win_in;
        end
        if (i_pat_we) begin
            r_pat <= i_ctrl.byte_value;
        end
        if (i_msk_we) begin
            r_msk <= i_ctrl.byte_value;
        end
        if (i_ctrl.align_load) begin
            r_apat <= i_rev_pat;
            r_amsk <= i_rev_msk;
        end else if (i_ctrl.align_shift) begin
            r_apat <= i_next_apat;
            r_amsk <= i_next_amsk;
        end else begin
            if (i_apat_we) begin
                r_apat <= i_ctrl.byte_value;
            end
            if (i_amsk_we) begin
                r_amsk <= i_ctrl.byte_value;
            end
        end
    end

    // In a backward search the window lines up with the pattern as stored; in a
    // forward search it lines up with the pattern reversed over its length.
    always_comb begin
        sel_pat = i_ctrl.backward ? r_pat : r_apat;
        sel_msk = i_ctrl.backward ? r_msk : r_amsk;
        eff_msk = i_ctrl.mask_en ? sel_msk : {BYTE_W{1'b1}};
        o_hit   = !i_active || ((i_win_in & eff_msk) == (sel_pat & eff_msk));
    end

    assign o_win  = r_win;
    assign o_pat  = r_pat;
    assign o_msk  = r_msk;
    assign o_apat = r_apat;
    assign o_amsk = r_amsk;

endmodule

`default_nettype wire

// File: rtl/mbps_seq.sv
// Alignment sequencer: after a pattern length write it reloads the reversed
// pattern and mask copies in the cells and shifts them into place.
// Depends on mbps_pkg.
`default_nettype none

module mbps_seq
    import mbps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_len_wr,
    input  wire logic [LEN_W-1:0] i_len,
    output t_align                o_align
);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;
    logic [LEN_W-1:0] shift_total;

    assign shift_total = LEN_W'(MAX_PATTERN_BYTES) - i_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        if (i_len_wr) begin
            n_state = ST_LOAD;
        end else begin
            unique case (r_state)
                ST_RUN: begin
                    n_state = ST_RUN;
                end
                ST_LOAD: begin
                    n_cnt = shift_total[IDX_W-1:0];
                    if (shift_total == '0) begin
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == IDX_W'(1)) begin
                        n_state = ST_RUN;
                    end
                end
                default: begin
                    n_state = ST_RUN;
                end
            endcase
        end
    end

    always_comb begin
        o_align.busy  = (r_state != ST_RUN);
        o_align.load  = (r_state == ST_LOAD);
        o_align.shift = (r_state == ST_SHIFT);
    end

endmodule

`default_nettype wire

// File: rtl/masked_byte_pattern_scan.sv
// Top level of the masked byte pattern scanner: configuration registers,
// window fill and result tracking, the row of cells and the output register.
// Depends on mbps_pkg, mbps_cell and mbps_seq.
//
// Usage: input transactions carry an action. Pattern and mask writes load one
// byte by index and give no result. Scan bytes shift into a window of
// MAX_PATTERN_BYTES cells; each cell compares the byte entering it against its
// pattern byte, masked when masking is on, and the row ANDs the cell results.
// The first match of a range gives one result transaction with found set and
// the lowest address of the match; later bytes of that range are dropped. A
// range that ends on its last byte without a match gives found clear and
// address zero. The input takes one transaction per cycle while ready is high;
// a result appears on the output channel in the cycle after the scan byte is
// accepted. The output register holds a result while the receiver stalls, and
// input ready drops while a result is waiting and not being taken, or while an
// alignment pass runs. A pattern length write starts such a pass: a load state
// and, for lengths under 32, shift states. Reset clears the window fill state,
// sets the length to one, clears masking and selects the forward search.
`default_nettype none

module masked_byte_pattern_scan
    import mbps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [ACTION_W-1:0]   i_action,
    input  wire logic [IDX_W-1:0]      i_entry_index,
    input  wire logic [BYTE_W-1:0]     i_byte_value,
    input  wire logic [ADDR_W-1:0]     i_byte_address,
    input  wire logic                  i_last_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_found,
    output logic [ADDR_W-1:0]          o_match_address
);

    logic [LEN_W-1:0]  r_len;
    logic              r_mask_en;
    logic              r_backward;
    logic [LEN_W-1:0]  r_fill;
    logic              r_done;
    logic              r_out_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_addr;

    logic [LEN_W-1:0]  n_len;
    logic [LEN_W-1:0]  n_fill;
    logic              len_wr;
    t_align            align;
    t_cell_ctrl        cell_ctrl;

    logic              in_acc;
    logic              scan_acc;
    logic              step;
    logic              pat_wr;
    logic              msk_wr;
    logic              align_hit;
    logic [IDX_W-1:0]  align_idx;
    logic              fill_ok;
    logic              match;
    logic              result;
    logic [ADDR_W-1:0] fwd_addr;

    logic [BYTE_W-1:0] w_win  [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] w_pat  [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] w_msk  [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] w_apat [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] w_amsk [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] w_hit;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_len = LEN_W'(1);
        end else if (LEN_W'(i_cfg_data) > LEN_W'(MAX_PATTERN_BYTES)) begin
            n_len = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            n_len = LEN_W'(i_cfg_data);
        end
    end

    assign len_wr = i_cfg_we && (i_cfg_index == CFG_PATTERN_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_W'(1);
            r_mask_en  <= 1'b0;
            r_backward <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LENGTH:  r_len      <= n_len;
                CFG_MASK_ENABLE:     r_mask_en  <= i_cfg_data[0];
                CFG_SEARCH_BACKWARD: r_backward <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mbps_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_len_wr(len_wr),
        .i_len   (r_len),
        .o_align (align)
    );

    assign o_in_ready = !align.busy && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign scan_acc   = in_acc && (i_action == ACT_SCAN_BYTE);
    assign step       = scan_acc && !r_done;
    assign pat_wr     = in_acc && (i_action == ACT_WRITE_PATTERN);
    assign msk_wr     = in_acc && (i_action == ACT_WRITE_MASK);

    // The reversed copy keeps pattern entry i in cell (length - 1 - i).
    assign align_hit  = ({1'b0, i_entry_index} < r_len);
    assign align_idx  = IDX_W'(r_len - 1'b1) - i_entry_index;

    always_comb begin
        cell_ctrl.scan_shift  = step;
        cell_ctrl.align_load  = align.load;
        cell_ctrl.align_shift = align.shift;
        cell_ctrl.mask_en     = r_mask_en;
        cell_ctrl.backward    = r_backward;
        cell_ctrl.byte_value  = i_byte_value;
    end

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        logic [BYTE_W-1:0] win_in;
        logic [BYTE_W-1:0] next_apat;
        logic [BYTE_W-1:0] next_amsk;

        if (k == 0) begin : g_head
            assign win_in = i_byte_value;
        end else begin : g_body
            assign win_in = w_win[k-1];
        end

        if (k == MAX_PATTERN_BYTES - 1) begin : g_tail
            assign next_apat = '0;
            assign next_amsk = '0;
        end else begin : g_inner
            assign next_apat = w_apat[k+1];
            assign next_amsk = w_amsk[k+1];
        end

        mbps_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_active   (LEN_W'(k) < r_len),
            .i_pat_we   (pat_wr && (i_entry_index == IDX_W'(k))),
            .i_msk_we   (msk_wr && (i_entry_index == IDX_W'(k))),
            .i_apat_we  (pat_wr && align_hit && (align_idx == IDX_W'(k))),
            .i_amsk_we  (msk_wr && align_hit && (align_idx == IDX_W'(k))),
            .i_win_in   (win_in),
            .i_rev_pat  (w_pat[MAX_PATTERN_BYTES-1-k]),
            .i_rev_msk  (w_msk[MAX_PATTERN_BYTES-1-k]),
            .i_next_apat(next_apat),
            .i_next_amsk(next_amsk),
            .o_win      (w_win[k]),
            .o_pat      (w_pat[k]),
            .o_msk      (w_msk[k]),
            .o_apat     (w_apat[k]),
            .o_amsk     (w_amsk[k]),
            .o_hit      (w_hit[k])
        );
    end

    assign n_fill   = (r_fill == LEN_W'(MAX_PATTERN_BYTES)) ? r_fill : r_fill + 1'b1;
    assign fill_ok  = (n_fill >= r_len);
    assign match    = fill_ok && (&w_hit);
    assign result   = step && (match || i_last_byte);
    assign fwd_addr = i_byte_address - ADDR_W'(r_len - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= 1'b0;
        end else if (scan_acc) begin
            if (i_last_byte) begin
                r_fill <= '0;
                r_done <= 1'b0;
            end else if (step) begin
                r_fill <= n_fill;
                if (match) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result) begin
            r_found <= match;
            if (!match) begin
                r_addr <= '0;
            end else if (r_backward) begin
                r_addr <= i_byte_address;
            end else begin
                r_addr <= fwd_addr;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_addr;

endmodule

`default_nettype wire
